[hdl/plane_linear_elastic_stress_top_macros.svh]
// Assertion macros for the plane linear elastic stress block.
// Used by plane_linear_elastic_stress_top; expects clk and rst_n in scope.
`ifndef PLANE_LINEAR_ELASTIC_STRESS_TOP_MACROS_SVH
`define PLANE_LINEAR_ELASTIC_STRESS_TOP_MACROS_SVH
`ifndef SYNTH
// checked only out of reset
`define PLES_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define PLES_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLES_ASSERT(name, prop, msg)
`define PLES_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

[hdl/ples_pkg.sv]
// Package for the plane linear elastic stress block: widths, register
// indexes, reset values, sequencer states and result types. No dependencies.
package ples_pkg;

  localparam int STRAIN_W    = 32;
  localparam int STRESS_W    = 64;
  localparam int MOD_W       = 63;
  localparam int E_W         = 32;
  localparam int NU_W        = 15;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 448;
  localparam int STRAIN_COMPONENTS_DEF = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_YOUNGS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POISSON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd2;

  localparam logic [E_W-1:0]  YOUNGS_RST  = 32'd1;
  localparam logic [NU_W-1:0] POISSON_RST = 15'd19661;
  localparam logic            MODE_RST    = 1'b0;

  localparam logic MODE_PLANE_STRESS = 1'b0;
  localparam logic MODE_PLANE_STRAIN = 1'b1;

  // divider: 80-bit dividend, 33-bit divisor, one quotient bit per cycle
  localparam int DIV_NUM_W  = 80;
  localparam int DIV_DEN_W  = 33;
  localparam int DIV_CNT_W  = 7;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 7'd80;

  // datapath accumulator width and fixed-point shifts
  localparam int ACC_W     = 100;
  localparam int PART_W    = 68;
  localparam int SUM_W     = 70;
  localparam int STRESS_SH = 28;
  localparam int ENERGY_SH = 29;

  typedef enum logic [5:0] {
    ST_G   = 6'b000001,  // shear modulus division
    ST_D   = 6'b000010,  // diagonal (stress) or c (strain) division
    ST_P   = 6'b000100,  // quotient times nu
    ST_O   = 6'b001000,  // plane strain coupling division
    ST_F   = 6'b010000,  // final moduli
    ST_RDY = 6'b100000   // moduli valid, stream open
  } seq_state_t;

  typedef struct packed {
    logic signed [STRESS_W-1:0] val;
    logic                       clip;
  } sat_res_t;

endpackage

[hdl/plane_linear_elastic_stress_top.sv]
// Plane stress / plane strain Hooke law: strain in, PK2 stress, energy, moduli out.
// Depends on ples_pkg and plane_linear_elastic_stress_top_macros.svh.
//
// Usage:
//  - in_* channel: one 2D strain per transfer, tdata = {yx, xy, yy, xx}, Q3.28.
//  - out_* channel: one result per input: tdata packs stress xx, yy, xy,
//    energy (64b each), then diag, offdiag, shear moduli (63b each);
//    tuser is the saturation flag.
//  - cfg_*: write-only registers E, nu, mode. Any write to a listed register
//    recomputes the moduli with a shared restoring divider (one quotient bit
//    per cycle). in_tready stays low meanwhile. Index 3 is ignored.
//  - After reset the same recompute runs for the reset values, then the
//    stream opens. Reset clears every pipeline valid bit.
//  - Datapath: 7 register stages (input, partial products, partial sums,
//    stresses, energy products, energy sums, output), one item per cycle
//    while the receiver is ready and no recompute runs; the products are 32x34
//    slices of the 63/64-bit operands, so each stage holds one multiply or one wide add.
//  - Receiver stall: valid bits collapse bubbles, so the block keeps taking
//    items until every stage holds one; nothing is dropped or repeated.
`include "plane_linear_elastic_stress_top_macros.svh"

module plane_linear_elastic_stress_top
  import ples_pkg::*;
#(
  parameter int STRAIN_COMPONENTS = STRAIN_COMPONENTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // strain_xx, strain_yy, strain_xy, strain_yx (32b each, lowest first)
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // stress_xx, stress_yy, stress_xy, strain_energy (64b each),
  // diag_modulus, offdiag_modulus, shear_modulus (63b each), 3 zero bits
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // saturated
  output logic                   out_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [E_W-1:0]         cfg_wdata
);

  localparam int NST = 7;

  // ---------------------------------------------------------------- config
  logic [E_W-1:0]  youngs_r;
  logic [NU_W-1:0] poisson_r;
  logic            mode_r;
  logic            cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == REG_YOUNGS || cfg_index == REG_POISSON ||
                              cfg_index == REG_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      youngs_r  <= YOUNGS_RST;
      poisson_r <= POISSON_RST;
      mode_r    <= MODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_YOUNGS:  youngs_r  <= cfg_wdata;
        REG_POISSON: poisson_r <= cfg_wdata[NU_W-1:0];
        REG_MODE:    mode_r    <= cfg_wdata[0];
        default:     ;
      endcase
    end
  end

  // ------------------------------------------------------ moduli sequencer
  seq_state_t              st_r, st_nxt;
  logic                    ld_r, ld_nxt;
  logic [DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0]    num_r, num_nxt;   // dividend, shifts into quotient
  logic [DIV_DEN_W:0]      rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0]    den_r, den_nxt;
  logic [48:0]             qd_r, qd_nxt;     // diag (stress) or c (strain)
  logic [63:0]             prod_r, prod_nxt;
  logic [MOD_W-1:0]        dmod_r, dmod_nxt, omod_r, omod_nxt, gmod_r, gmod_nxt;

  logic [DIV_DEN_W:0]      rem_sh;
  logic [DIV_DEN_W+1:0]    diff;
  logic                    ge;
  logic [DIV_NUM_W-1:0]    quo;
  logic [DIV_NUM_W-1:0]    num_sel;
  logic [DIV_DEN_W-1:0]    den_sel;
  logic [29:0]             psq;
  logic [16:0]             one_plus_nu;

  assign rem_sh      = {rem_r[DIV_DEN_W-1:0], num_r[DIV_NUM_W-1]};
  assign diff        = {1'b0, rem_sh} - {2'b00, den_r};
  assign ge          = ~diff[DIV_DEN_W+1];
  assign quo         = {num_r[DIV_NUM_W-2:0], ge};
  assign psq         = poisson_r * poisson_r;
  assign one_plus_nu = {2'b10, poisson_r};

  // dividend and divisor for the division that starts in this state
  always_comb begin
    num_sel = '0;
    den_sel = '0;
    case (st_r)
      ST_G: begin
        num_sel = {17'd0, youngs_r, 31'd0};
        den_sel = {16'd0, one_plus_nu};
      end
      ST_D: begin
        if (mode_r == MODE_PLANE_STRESS) begin
          num_sel = {youngs_r, 48'd0};
          den_sel = 33'h1_0000_0000 - {3'b000, psq};
        end else begin
          num_sel = {16'd0, youngs_r, 32'd0};
          den_sel = {16'd0, one_plus_nu};
        end
      end
      ST_O: begin
        num_sel = {16'd0, prod_r};
        den_sel = {16'd0, 17'h10000 - {1'b0, poisson_r, 1'b0}};
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt   = st_r;
    ld_nxt   = ld_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    qd_nxt   = qd_r;
    prod_nxt = prod_r;
    dmod_nxt = dmod_r;
    omod_nxt = omod_r;
    gmod_nxt = gmod_r;
    case (st_r)
      ST_G, ST_D, ST_O: begin
        if (ld_r) begin
          num_nxt = num_sel;
          den_nxt = den_sel;
          rem_nxt = '0;
          cnt_nxt = DIV_STEPS;
          ld_nxt  = 1'b0;
        end else begin
          num_nxt = quo;
          rem_nxt = ge ? diff[DIV_DEN_W:0] : rem_sh;
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == 7'd1) begin
            ld_nxt = 1'b1;
            case (st_r)
              ST_G: begin
                gmod_nxt = quo[MOD_W-1:0];
                st_nxt   = ST_D;
              end
              ST_D: begin
                qd_nxt = quo[48:0];
                st_nxt = ST_P;
              end
              default: st_nxt = ST_F;
            endcase
          end
        end
      end
      ST_P: begin
        prod_nxt = qd_r * poisson_r;
        st_nxt   = (mode_r == MODE_PLANE_STRESS) ? ST_F : ST_O;
      end
      ST_F: begin
        if (mode_r == MODE_PLANE_STRESS) begin
          dmod_nxt = {14'd0, qd_r};
          omod_nxt = {15'd0, prod_r[63:16]};
        end else begin
          omod_nxt = num_r[MOD_W-1:0];
          dmod_nxt = num_r[MOD_W-1:0] + {14'd0, qd_r};
        end
        st_nxt = ST_RDY;
      end
      ST_RDY: ;
      default: st_nxt = ST_G;
    endcase
    if (cfg_hit) begin
      st_nxt = ST_G;
      ld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_G;
      ld_r  <= 1'b1;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      ld_r  <= ld_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    qd_r   <= qd_nxt;
    prod_r <= prod_nxt;
    dmod_r <= dmod_nxt;
    omod_r <= omod_nxt;
    gmod_r <= gmod_nxt;
  end

  // --------------------------------------------------------- arithmetic
  // unsigned 32b slice times signed 34b strain
  function automatic logic signed [PART_W-1:0] mul_u(input logic [31:0] a,
                                                     input logic signed [33:0] x);
    logic signed [32:0] ax;
    ax = $signed({1'b0, a});
    return ax * x;
  endfunction

  function automatic logic signed [PART_W-1:0] mul_s(input logic signed [31:0] a,
                                                     input logic signed [33:0] x);
    return a * x;
  endfunction

  function automatic logic signed [ACC_W-1:0] combine(input logic signed [SUM_W-1:0] h,
                                                      input logic signed [SUM_W-1:0] l);
    logic signed [ACC_W-1:0] hx;
    logic signed [ACC_W-1:0] lx;
    hx = h;
    lx = l;
    return (hx <<< 32) + lx;
  endfunction

  function automatic sat_res_t sat64(input logic signed [ACC_W-1:0] v);
    sat_res_t r;
    if ((&v[ACC_W-1:STRESS_W-1]) || !(|v[ACC_W-1:STRESS_W-1])) begin
      r.val  = v[STRESS_W-1:0];
      r.clip = 1'b0;
    end else begin
      r.val  = v[ACC_W-1] ? {1'b1, {(STRESS_W-1){1'b0}}} : {1'b0, {(STRESS_W-1){1'b1}}};
      r.clip = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [33:0] sx34(input logic [31:0] e);
    return {{2{e[31]}}, e};
  endfunction

  // ----------------------------------------------------------- pipeline
  logic [NST-1:0] v_r, v_nxt;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_tready;
    for (int k = NST-2; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end

  assign in_tready = en[0] && (st_r == ST_RDY);

  always_comb begin
    v_nxt[0] = en[0] ? (in_tvalid && in_tready) : v_r[0];
    for (int k = 1; k < NST; k++) v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  // strains ride along every stage (exx, eyy, exy, eyx)
  logic [31:0] exx_r [NST], eyy_r [NST], exy_r [NST], eyx_r [NST];
  logic signed [32:0] g1_r;

  logic [31:0] eyx_in;
  assign eyx_in = (STRAIN_COMPONENTS > 3) ? in_tdata[127:96] : 32'd0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      exx_r[0] <= in_tdata[31:0];
      eyy_r[0] <= in_tdata[63:32];
      exy_r[0] <= in_tdata[95:64];
      eyx_r[0] <= eyx_in;
      g1_r     <= $signed({in_tdata[95], in_tdata[95:64]}) +
                  $signed({eyx_in[31], eyx_in});
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        exx_r[k] <= exx_r[k-1];
        eyy_r[k] <= eyy_r[k-1];
        exy_r[k] <= exy_r[k-1];
        eyx_r[k] <= eyx_r[k-1];
      end
    end
  end

  // stage 2: modulus slices times strains
  logic signed [PART_W-1:0] a_dl_r, a_dh_r, a_ol_r, a_oh_r;   // sxx terms
  logic signed [PART_W-1:0] b_ol_r, b_oh_r, b_dl_r, b_dh_r;   // syy terms
  logic signed [PART_W-1:0] c_gl_r, c_gh_r;                   // sxy terms
  logic signed [33:0] xx1, yy1, gs1;

  assign xx1 = sx34(exx_r[0]);
  assign yy1 = sx34(eyy_r[0]);
  assign gs1 = {g1_r[32], g1_r};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      a_dl_r <= mul_u(dmod_r[31:0], xx1);
      a_dh_r <= mul_u({1'b0, dmod_r[62:32]}, xx1);
      a_ol_r <= mul_u(omod_r[31:0], yy1);
      a_oh_r <= mul_u({1'b0, omod_r[62:32]}, yy1);
      b_ol_r <= mul_u(omod_r[31:0], xx1);
      b_oh_r <= mul_u({1'b0, omod_r[62:32]}, xx1);
      b_dl_r <= mul_u(dmod_r[31:0], yy1);
      b_dh_r <= mul_u({1'b0, dmod_r[62:32]}, yy1);
      c_gl_r <= mul_u(gmod_r[31:0], gs1);
      c_gh_r <= mul_u({1'b0, gmod_r[62:32]}, gs1);
    end
  end

  // stage 3: partial sums
  logic signed [SUM_W-1:0] xh_r, xl_r, yh_r, yl_r, gh_r, gl_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      xh_r <= SUM_W'(a_dh_r) + SUM_W'(a_oh_r);
      xl_r <= SUM_W'(a_dl_r) + SUM_W'(a_ol_r);
      yh_r <= SUM_W'(b_dh_r) + SUM_W'(b_oh_r);
      yl_r <= SUM_W'(b_dl_r) + SUM_W'(b_ol_r);
      gh_r <= SUM_W'(c_gh_r);
      gl_r <= SUM_W'(c_gl_r);
    end
  end

  // stage 4: stresses, floor shift and clip
  sat_res_t sxx_c, syy_c, sxy_c;
  logic signed [STRESS_W-1:0] sxx_r [4:NST-1], syy_r [4:NST-1], sxy_r [4:NST-1];
  logic sat_r [4:NST-1];

  assign sxx_c = sat64(combine(xh_r, xl_r) >>> STRESS_SH);
  assign syy_c = sat64(combine(yh_r, yl_r) >>> STRESS_SH);
  assign sxy_c = sat64(combine(gh_r, gl_r) >>> STRESS_SH);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sxx_r[4] <= sxx_c.val;
      syy_r[4] <= syy_c.val;
      sxy_r[4] <= sxy_c.val;
      sat_r[4] <= sxx_c.clip | syy_c.clip | sxy_c.clip;
    end
    for (int k = 5; k < NST; k++) begin
      if (en[k-1]) begin
        sxx_r[k] <= sxx_r[k-1];
        syy_r[k] <= syy_r[k-1];
        sxy_r[k] <= sxy_r[k-1];
        sat_r[k] <= sat_r[k-1];
      end
    end
  end

  // stage 5: energy products, stress slices times strains
  logic signed [PART_W-1:0] ex_l_r, ex_h_r, ey_l_r, ey_h_r;
  logic signed [PART_W-1:0] ea_l_r, ea_h_r, eb_l_r, eb_h_r;
  logic signed [33:0] xx4, yy4, xy4, yx4;

  assign xx4 = sx34(exx_r[3]);
  assign yy4 = sx34(eyy_r[3]);
  assign xy4 = sx34(exy_r[3]);
  assign yx4 = sx34(eyx_r[3]);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      ex_l_r <= mul_u(sxx_r[4][31:0], xx4);
      ex_h_r <= mul_s(sxx_r[4][63:32], xx4);
      ey_l_r <= mul_u(syy_r[4][31:0], yy4);
      ey_h_r <= mul_s(syy_r[4][63:32], yy4);
      ea_l_r <= mul_u(sxy_r[4][31:0], xy4);
      ea_h_r <= mul_s(sxy_r[4][63:32], xy4);
      eb_l_r <= mul_u(sxy_r[4][31:0], yx4);
      eb_h_r <= mul_s(sxy_r[4][63:32], yx4);
    end
  end

  // stage 6: energy partial sums
  logic signed [SUM_W-1:0] eh_r, el_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      eh_r <= SUM_W'(ex_h_r) + SUM_W'(ey_h_r) + SUM_W'(ea_h_r) + SUM_W'(eb_h_r);
      el_r <= SUM_W'(ex_l_r) + SUM_W'(ey_l_r) + SUM_W'(ea_l_r) + SUM_W'(eb_l_r);
    end
  end

  // stage 7: output register
  sat_res_t en_c;
  logic signed [STRESS_W-1:0] o_sxx_r, o_syy_r, o_sxy_r, o_en_r;
  logic o_sat_r;

  assign en_c = sat64(combine(eh_r, el_r) >>> ENERGY_SH);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      o_sxx_r <= sxx_r[6];
      o_syy_r <= syy_r[6];
      o_sxy_r <= sxy_r[6];
      o_en_r  <= en_c.val;
      o_sat_r <= sat_r[6] | en_c.clip;
    end
  end

  assign out_tvalid = v_r[NST-1];
  assign out_tuser  = o_sat_r;
  assign out_tdata  = {3'b000, gmod_r, omod_r, dmod_r, o_en_r, o_sxy_r, o_syy_r, o_sxx_r};

  // ---------------------------------------------------------- assertions
  `PLES_ASSERT(a_accept_only_ready, in_tready |-> (st_r == ST_RDY), "accept during recompute")
  `PLES_ASSERT(a_cfg_closes_stream, cfg_hit |=> !in_tready, "stream open after cfg write")
  `PLES_ASSERT(a_cnt_in_div, (cnt_r != 7'd0) |-> (st_r == ST_G || st_r == ST_D || st_r == ST_O), "divider count outside division")
  `PLES_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule
